// ===== sv/fnvrh_pkg.sv =====
// Package for the FNV-1 64-bit record hasher.
// Holds the hash constants, request codes, sequencer states and the byte-step function.
// No dependencies.
package fnvrh_pkg;

  // Bytes carried by one transaction, and the widest count the sequencer runs
  localparam int unsigned BYTES_PER_ITEM = 8;
  localparam int unsigned NULL_BYTES     = 4;
  localparam int unsigned MAX_CNT        = (BYTES_PER_ITEM > NULL_BYTES) ?
                                           BYTES_PER_ITEM : NULL_BYTES;
  localparam int unsigned CNT_W          = $clog2(MAX_CNT + 1);

  // Hash constants (starting value kept with halves swapped, as specified)
  localparam logic [63:0] START_VALUE  = 64'h84222325cbf29ce4;
  localparam logic [63:0] NULL_PATTERN = 64'h000000000a0b0c0d;
  // Prime is 2^40 + 0x1b3: shift-add plus a narrow constant multiply
  localparam logic [8:0]  PRIME_LO     = 9'h1b3;
  localparam int unsigned PRIME_SHIFT  = 40;

  // Request type codes
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_NULL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // One FNV-1 step: multiply by the prime mod 2^64, then XOR in the byte
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [72:0] lo_prod;
    logic [63:0] prod;
    lo_prod = h * PRIME_LO;
    prod    = lo_prod[63:0] + {h[63-PRIME_SHIFT:0], {PRIME_SHIFT{1'b0}}};
    return prod ^ {56'b0, b};
  endfunction

endpackage

// ===== sv/fnv1_64_record_hasher.sv =====
// Top level of the FNV-1 64-bit record hasher.
// Depends on fnvrh_pkg.
// An accepted transaction is taken in while idle, then its n bytes are hashed, where n is
// byte_count saturated to 8, or 4 for a null marker: one byte per cycle through the single
// shared multiply-xor unit, whose result feeds the next byte; a zero count takes one step
// that leaves the hash unchanged. The input is stalled while an item is in work. A last
// item finishes only when the output register is free, so a stalled result can delay it.
module fnv1_64_record_hasher
  import fnvrh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] payload_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  state_e             state_q, state_d;
  logic [63:0]        hash_q, hash_d;
  logic [63:0]        bytes_q, bytes_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_hash_q, out_hash_d;

  logic               in_accept;
  logic               out_free;
  logic               done;
  logic [63:0]        step_hash;
  logic [CNT_W-1:0]   sat_cnt;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign done      = (cnt_q <= CNT_W'(1));

  // Saturate the byte count to the item width
  assign sat_cnt = (byte_count_i > 4'(BYTES_PER_ITEM)) ? CNT_W'(BYTES_PER_ITEM)
                                                       : CNT_W'(byte_count_i);

  // Shared byte-step unit; a zero count leaves the hash untouched
  assign step_hash = (cnt_q == '0) ? hash_q : fnv_step(hash_q, bytes_q[7:0]);

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    bytes_d     = bytes_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d  = last_i;
          state_d = ST_BUSY;
          if (req_type_i == REQ_NULL) begin
            bytes_d = NULL_PATTERN;
            cnt_d   = CNT_W'(NULL_BYTES);
          end else begin
            bytes_d = payload_i;
            cnt_d   = sat_cnt;
          end
        end
      end
      ST_BUSY: begin
        if (!done) begin
          hash_d  = step_hash;
          bytes_d = {8'b0, bytes_q[63:8]};
          cnt_d   = cnt_q - CNT_W'(1);
        end else if (!last_q) begin
          hash_d  = step_hash;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else if (out_free) begin
          // Record ends: hand the hash to the output and reload
          out_hash_d  = step_hash;
          out_valid_d = 1'b1;
          hash_d      = START_VALUE;
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= START_VALUE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bytes_q    <= bytes_d;
    out_hash_q <= out_hash_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

// ===== sv/fnvrh_checker.sv =====
// Port-level checker for the FNV-1 64-bit record hasher, with its bind.
// Depends on fnvrh_pkg and the top level fnv1_64_record_hasher.
module fnvrh_checker
  import fnvrh_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        req_type_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_value_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Block goes busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o)
    else $error("input not stalled after accept");

  // A result cannot appear the cycle after an accept into an empty output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // A null marker ending a record yields its hash after four byte steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_NULL) && last_i && !out_valid_o |=> ##4 out_valid_o)
    else $error("null marker result missing");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled result changed");

endmodule

bind fnv1_64_record_hasher fnvrh_checker u_fnvrh_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for fnv1_64_record_hasher: directed table plus random records,
// with random idle bursts on both channels and an in-line FNV-1 64-bit predictor.
// Depends on fnvrh_pkg and the fnv1_64_record_hasher RTL.
`timescale 1ns / 100ps

module testbench;
  import fnvrh_pkg::*;

  // Hash constants for the predictor
  localparam logic [63:0] HASH_SEED    = 64'h84222325cbf29ce4;
  localparam logic [63:0] HASH_PRIME   = 64'h100000001b3;
  localparam logic [63:0] NULL_MARKER  = 64'h000000000a0b0c0d;
  localparam int unsigned NULL_NBYTES  = 4;

  localparam int unsigned RAND_ITEMS   = 1400;
  localparam int unsigned QUIET_ITEMS  = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One row of the directed table
  typedef struct packed {
    logic        req_type;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last;
    logic        typed;      // expected hash given in the row
    logic [63:0] hash;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // empty records right after reset: seed comes straight out
    '{REQ_DATA, 64'h0000000000000000, 4'd0,  1'b1, 1'b1, HASH_SEED},
    '{REQ_DATA, 64'hffffffffffffffff, 4'd0,  1'b1, 1'b1, HASH_SEED},
    // full-width payload extremes
    '{REQ_DATA, 64'hffffffffffffffff, 4'd8,  1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'h0000000000000000, 4'd8,  1'b1, 1'b0, 64'h0},
    // null marker ignores payload and count
    '{REQ_NULL, 64'hffffffffffffffff, 4'd15, 1'b1, 1'b0, 64'h0},
    '{REQ_NULL, 64'h0000000000000000, 4'd0,  1'b0, 1'b0, 64'h0},
    // oversize count saturates
    '{REQ_DATA, 64'hffffffffffffffff, 4'd15, 1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'h0123456789abcdef, 4'd9,  1'b0, 1'b0, 64'h0},
    '{REQ_DATA, 64'hfedcba9876543210, 4'd1,  1'b0, 1'b0, 64'h0},
    // zero count closing a non-empty record
    '{REQ_DATA, 64'hffffffffffffffff, 4'd0,  1'b1, 1'b0, 64'h0},
    // bytes above the count must be dropped
    '{REQ_DATA, 64'hffffffffffa5c3e1, 4'd3,  1'b1, 1'b0, 64'h0},
    // mixed multi-item record
    '{REQ_DATA, 64'h0011223344556677, 4'd4,  1'b0, 1'b0, 64'h0},
    '{REQ_NULL, 64'ha5a5a5a5a5a5a5a5, 4'd7,  1'b0, 1'b0, 64'h0},
    '{REQ_DATA, 64'h8899aabbccddeeff, 4'd8,  1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'h5555555555555555, 4'd12, 1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'haaaaaaaaaaaaaaaa, 4'd10, 1'b1, 1'b0, 64'h0},
    // back-to-back null markers
    '{REQ_NULL, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0},
    '{REQ_NULL, 64'h0000000000000000, 4'd0,  1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'h0000000000000080, 4'd1,  1'b1, 1'b0, 64'h0},
    // zero count in the middle of a record
    '{REQ_DATA, 64'h0000000000000000, 4'd0,  1'b0, 1'b0, 64'h0},
    '{REQ_DATA, 64'h00000000000000ff, 4'd1,  1'b1, 1'b0, 64'h0},
    '{REQ_DATA, 64'h0000000000000000, 4'd0,  1'b1, 1'b1, HASH_SEED}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [63:0] payload_i;
  logic [3:0]  byte_count_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] hash_value_o;

  // Predictor state and bookkeeping
  logic [63:0] record_hash;
  logic [63:0] pending_hashes [$];
  logic [63:0] due_hash;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned hashes_checked;
  int unsigned records_closed;
  int unsigned null_items;
  int unsigned oversize_items;
  int unsigned drain_pauses;
  int unsigned cycle_count;
  bit          quiet_tail;

  fnv1_64_record_hasher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .payload_i    (payload_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // FNV-1: multiply by the prime (mod 2^64), then xor in the byte, lowest byte first
  function automatic logic [63:0] fold_bytes(input logic [63:0] h, input logic [63:0] bytes,
                                             input int unsigned nbytes);
    logic [63:0] acc;
    acc = h;
    for (int unsigned k = 0; k < nbytes; k++) begin
      acc = acc * HASH_PRIME;
      acc = acc ^ {56'b0, bytes[8*k +: 8]};
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Drive one transaction, wait for acceptance, then update the predicted record hash
  task automatic send_item(input logic rt, input logic [63:0] pl, input logic [3:0] cnt,
                           input logic lst, input bit typed, input logic [63:0] typed_hash);
    bit          stalled;
    int unsigned nbytes;
    in_valid_i   <= 1'b1;
    req_type_i   <= rt;
    payload_i    <= pl;
    byte_count_i <= cnt;
    last_i       <= lst;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items_sent++;

    if (rt == REQ_NULL) begin
      record_hash = fold_bytes(record_hash, NULL_MARKER, NULL_NBYTES);
      null_items++;
    end else begin
      nbytes = (cnt > BYTES_PER_ITEM) ? BYTES_PER_ITEM : cnt;
      if (cnt > BYTES_PER_ITEM) oversize_items++;
      record_hash = fold_bytes(record_hash, pl, nbytes);
    end
    if (lst) begin
      pending_hashes.push_back(typed ? typed_hash : record_hash);
      record_hash = HASH_SEED;
      records_closed++;
    end

    // random sender gap
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stimulus: reset, directed table, random records
  initial begin
    int unsigned rec_len;
    int unsigned rand_start;
    logic        rt;
    logic [3:0]  cnt;
    bit          forced_drain;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    req_type_i   <= REQ_DATA;
    payload_i    <= '0;
    byte_count_i <= '0;
    last_i       <= 1'b0;
    record_hash   = HASH_SEED;
    mismatches    = 0;
    items_sent    = 0;
    hashes_checked = 0;
    records_closed = 0;
    null_items    = 0;
    oversize_items = 0;
    drain_pauses  = 0;
    quiet_tail    = 1'b0;
    forced_drain  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < N_DIRECTED; r++) begin
      send_item(DIRECTED[r].req_type, DIRECTED[r].payload, DIRECTED[r].byte_count,
                DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].hash);
    end

    // random records; every record boundary may hold the sender until all hashes are out
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      if (items_sent - rand_start >= RAND_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if ((!forced_drain && items_sent - rand_start >= RAND_ITEMS / 2) ||
          (!quiet_tail && $urandom_range(0, 39) == 0)) begin
        forced_drain = 1'b1;
        drain_pauses++;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_hashes.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 11) == 0) begin
        // empty record
        send_item(REQ_DATA, {$urandom, $urandom}, 4'd0, 1'b1, 1'b0, '0);
      end else begin
        rec_len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < rec_len; i++) begin
          rt  = ($urandom_range(0, 7) == 0) ? REQ_NULL : REQ_DATA;
          cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
          send_item(rt, {$urandom, $urandom}, cnt, i == rec_len - 1, 1'b0, '0);
        end
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_hashes.size() != 0) report_mismatch("hash never emitted", pending_hashes[0], '0);

    $display("Sent %0d transactions in %0d records (%0d null markers, %0d oversize counts).",
             items_sent, records_closed, null_items, oversize_items);
    $display("Checked %0d hashes; %0d full drains; %0d mismatches.",
             hashes_checked, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Output stall bursts, with clean stretches; none in the tail
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet_tail) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk_i);
          end
          2: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(20, 60)) @(posedge clk_i);
          end
          default: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  // Result check: sampled mid-cycle, accepted at the following rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("hash with no record pending", '0, hash_value_o);
      end else begin
        due_hash = pending_hashes.pop_front();
        hashes_checked++;
        if (hash_value_o !== due_hash) report_mismatch("hash_value", due_hash, hash_value_o);
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d hashes still pending",
               cycle_count, pending_hashes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
